// ----- design/sliding_window_peak_bitrate_macros.svh -----
// Assertion macros shared by the RTL of the peak bitrate tracker.
`ifndef SLIDING_WINDOW_PEAK_BITRATE_MACROS_SVH
`define SLIDING_WINDOW_PEAK_BITRATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWPB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/swpb_pkg.sv -----
// Types and constants of the sliding window peak bitrate tracker.
`default_nettype none

package swpb_pkg;

  localparam int TS_W       = 18;  // media timescale width
  localparam int TICK_W     = 16;  // frame duration in ticks
  localparam int BYTES_W    = 16;  // frame size field
  localparam int DIVR_W     = 2;   // duration divisor register
  localparam int CFG_DATA_W = 18;
  localparam int RATE_W     = 32;
  localparam int STEP_W     = 5;   // step counter for multiply and divide loops

  localparam logic [TS_W-1:0]   TS_RESET   = 18'd44100;
  localparam logic [DIVR_W-1:0] DIVR_RESET = 2'd1;

  // floor(x / 3) == (x * 43691) >> 17 for any 16-bit x
  localparam logic [16:0] DIV3_RECIP = 17'd43691;
  localparam int          DIV3_SHIFT = 17;

  typedef enum logic {
    OP_FRAME    = 1'b0,
    OP_FINALIZE = 1'b1
  } op_e;

  typedef enum logic {
    REG_TIMESCALE = 1'b0,
    REG_DIVISOR   = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_EV_DIFF,
    ST_EV_CMP,
    ST_DROP,
    ST_PUSH_B,
    ST_PUSH_T,
    ST_CHECK,
    ST_MUL,
    ST_ADD_D,
    ST_SAT,
    ST_DIV,
    ST_PEAK,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                opcode;
    logic [BYTES_W-1:0] frame_bytes;
    logic [TICK_W-1:0]  frame_samples;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] peak_bitrate;
    logic [RATE_W-1:0] window_bitrate;
    logic              window_evaluated;
    logic              fifo_overflow;
  } out_item_t;

  typedef struct packed {
    reg_idx_e              index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

endpackage

`default_nettype wire

// ----- design/swpb_stream_if.sv -----
// Valid/ready channel carrying one payload word per transaction.
`default_nettype none

interface swpb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/swpb_alu.sv -----
// Shared add/subtract unit with unsigned compare flag.
`default_nettype none

module swpb_alu #(
  parameter int W = 8
) (
  input  wire logic [W-1:0]    a_i,
  input  wire logic [W-1:0]    b_i,
  input  wire swpb_pkg::alu_op_e op_i,
  output logic      [W-1:0]    sum_o,
  output logic                 ge_o
);
  import swpb_pkg::*;

  logic [W:0]   total;
  logic [W-1:0] b_eff;
  logic         cin;

  always_comb begin
    cin   = (op_i == ALU_SUB);
    b_eff = cin ? ~b_i : b_i;
    total = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, cin};
  end

  assign sum_o = total[W-1:0];
  // on subtract, carry out means no borrow: a >= b
  assign ge_o  = total[W];

endmodule

`default_nettype wire

// ----- design/sliding_window_peak_bitrate.sv -----
// Top level of the sliding window peak bitrate tracker.
// Usage:
//   in_if  : one transaction per frame (opcode FRAME) or per finalize request.
//   out_if : exactly one result transaction per input transaction, in order.
//   cfg_if : register writes (index 0 media_timescale, 1 duration_divisor);
//            always ready, write only while no item is in flight.
// Each item runs through one shared adder under a sequencer. A frame is first
// pushed (byte sum, then tick sum); on FIFO overflow the oldest entry is read
// and dropped before the push. Eviction reads, subtracts and compares each
// FIFO entry examined and drops those that leave; the window check and the
// output register load follow. An evaluated window adds a shift-add multiply
// (one timescale bit per cycle), the dividend add, a saturation check, a
// restoring divide (one quotient bit per cycle, skipped when the rate
// saturates) and a peak compare. Only one item is in flight: the next item is
// accepted once the previous result is loaded into the output register.
// Reset clears the window, the peak and the FIFO pointers and restores the
// register defaults; stored entries are not cleared (only live ones are read).
// If the receiver stalls, the result waits in the output register and the
// sequencer holds its final step until the register frees up.
`default_nettype none

module sliding_window_peak_bitrate #(
  parameter int FIFO_DEPTH = 128,
  parameter int SIZE_BITS  = 16
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  swpb_stream_if.sink   in_if,
  swpb_stream_if.source out_if,
  swpb_stream_if.sink   cfg_if
);
  import swpb_pkg::*;

  `include "sliding_window_peak_bitrate_macros.svh"

  // ---------------------------------------------------------------------------
  // Widths
  // ---------------------------------------------------------------------------
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int ENTRY_W = SIZE_BITS + TICK_W;
  localparam int WB_W    = SIZE_BITS + CNT_W;       // window byte sum
  localparam int WT_W    = TICK_W + CNT_W;          // window tick sum
  localparam int NUM_W   = WB_W + 3 + TS_W;         // bytes * 8 * timescale
  localparam int ALU_W   = NUM_W + 2;               // 2 * num + ticks
  localparam int REM_W   = WT_W + 1;                // divider remainder
  localparam int SAT_W   = (SIZE_BITS > BYTES_W) ? SIZE_BITS : BYTES_W;

  localparam logic [SIZE_BITS-1:0] SIZE_MAX  = '1;
  localparam logic [CNT_W-1:0]     CNT_FULL  = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0]     PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [TS_W-1:0]        ts_q, ts_d;
  logic [DIVR_W-1:0]      divr_q, divr_d;

  logic [PTR_W-1:0]       head_q, head_d;
  logic [PTR_W-1:0]       tail_q, tail_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [WB_W-1:0]        wb_q, wb_d;
  logic [WT_W-1:0]        wt_q, wt_d;
  logic [RATE_W-1:0]      peak_q, peak_d;

  logic                   fin_q, fin_d;          // item is a finalize
  logic                   ovf_q, ovf_d;          // overflow drop happened
  logic                   ovf_pend_q, ovf_pend_d;// overflow drop not yet done
  logic                   eval_q, eval_d;
  logic [SIZE_BITS-1:0]   size_q, size_d;
  logic [TICK_W-1:0]      tick_q, tick_d;
  logic [ALU_W-1:0]       acc_q, acc_d;
  logic [RATE_W-1:0]      quot_q, quot_d;        // multiplier bits, then quotient
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [STEP_W-1:0]      cnt_q, cnt_d;

  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  // entry FIFO storage; read data registered, always addressed at the head
  logic [ENTRY_W-1:0]     entry_mem_q [FIFO_DEPTH];
  logic [ENTRY_W-1:0]     rd_data_q;
  logic                   mem_we;

  logic [SIZE_BITS-1:0]   head_size;
  logic [TICK_W-1:0]      head_tick;

  // shared adder
  logic [ALU_W-1:0]       alu_a, alu_b, alu_sum;
  alu_op_e                alu_op;
  logic                   alu_ge;

  // input capture helpers
  logic                   in_fire, cfg_fire, out_free;
  logic [SAT_W-1:0]       bytes_ext;
  logic [SIZE_BITS-1:0]   size_in;
  logic [TICK_W-1:0]      tick_in;
  logic [TICK_W+16:0]     div3_prod;
  logic                   fifo_full;
  logic [REM_W:0]         div_trial;

  assign head_size = rd_data_q[ENTRY_W-1:TICK_W];
  assign head_tick = rd_data_q[TICK_W-1:0];

  assign in_if.ready  = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;
  assign out_free     = !out_valid_q || out_if.ready;
  assign fifo_full    = (count_q == CNT_FULL);
  assign div_trial    = {rem_q, quot_q[RATE_W-1]};

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  swpb_alu #(
    .W (ALU_W)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  // ---------------------------------------------------------------------------
  // Frame size clamp and duration divide (divisor 0 acts as 1)
  // ---------------------------------------------------------------------------
  always_comb begin
    bytes_ext = SAT_W'(in_if.data.frame_bytes);
    size_in   = (bytes_ext > SAT_W'(SIZE_MAX)) ? SIZE_MAX : SIZE_BITS'(bytes_ext);
    div3_prod = in_if.data.frame_samples * DIV3_RECIP;
    case (divr_q)
      2'd2:    tick_in = in_if.data.frame_samples >> 1;
      2'd3:    tick_in = TICK_W'(div3_prod >> DIV3_SHIFT);
      default: tick_in = in_if.data.frame_samples;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_if.data.opcode == OP_FINALIZE) begin
            state_d = (count_q == '0) ? ST_CHECK : ST_RD_WAIT;
          end else begin
            state_d = fifo_full ? ST_RD_WAIT : ST_PUSH_B;
          end
        end
      end
      ST_RD_WAIT: state_d = ST_EV_DIFF;
      ST_EV_DIFF: state_d = ovf_pend_q ? ST_DROP : ST_EV_CMP;
      ST_EV_CMP:  state_d = alu_ge ? ST_DROP : ST_CHECK;
      ST_DROP: begin
        if (ovf_pend_q) begin
          state_d = ST_PUSH_B;
        end else if (count_q == CNT_W'(1)) begin
          state_d = ST_CHECK;
        end else begin
          state_d = ST_RD_WAIT;
        end
      end
      ST_PUSH_B:  state_d = ST_PUSH_T;
      ST_PUSH_T:  state_d = ST_RD_WAIT;
      ST_CHECK: begin
        if ((wt_q != '0) && (fin_q || alu_ge)) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MUL:     state_d = (cnt_q == '0) ? ST_ADD_D : ST_MUL;
      ST_ADD_D:   state_d = ST_SAT;
      ST_SAT:     state_d = alu_ge ? ST_PEAK : ST_DIV;
      ST_DIV:     state_d = (cnt_q == '0) ? ST_PEAK : ST_DIV;
      ST_PEAK:    state_d = ST_DONE;
      ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: shared adder operands and FIFO write strobe
  // ---------------------------------------------------------------------------
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    mem_we = 1'b0;
    case (state_q)
      ST_EV_DIFF: begin  // window ticks without the oldest entry
        alu_a  = ALU_W'(wt_q);
        alu_b  = ALU_W'(head_tick);
        alu_op = ALU_SUB;
      end
      ST_EV_CMP: begin   // does the rest still cover one second?
        alu_a  = acc_q;
        alu_b  = ALU_W'(ts_q);
        alu_op = ALU_SUB;
      end
      ST_DROP: begin
        alu_a  = ALU_W'(wb_q);
        alu_b  = ALU_W'(head_size);
        alu_op = ALU_SUB;
      end
      ST_PUSH_B: begin
        alu_a  = ALU_W'(wb_q);
        alu_b  = ALU_W'(size_q);
        mem_we = 1'b1;
      end
      ST_PUSH_T: begin
        alu_a  = ALU_W'(wt_q);
        alu_b  = ALU_W'(tick_q);
      end
      ST_CHECK: begin
        alu_a  = ALU_W'(wt_q);
        alu_b  = ALU_W'(ts_q);
        alu_op = ALU_SUB;
      end
      ST_MUL: begin      // acc = 2*acc + bit * (bytes * 8), MSB first
        alu_a  = acc_q << 1;
        alu_b  = quot_q[RATE_W-1] ? ALU_W'({wb_q, 3'b000}) : '0;
      end
      ST_ADD_D: begin    // dividend = 2*num + ticks (round half up)
        alu_a  = acc_q << 1;
        alu_b  = ALU_W'(wt_q);
      end
      ST_SAT: begin      // quotient >= 2^32 iff dividend[hi] >= 2*ticks
        alu_a  = acc_q >> RATE_W;
        alu_b  = ALU_W'({wt_q, 1'b0});
        alu_op = ALU_SUB;
      end
      ST_DIV: begin
        alu_a  = ALU_W'(div_trial);
        alu_b  = ALU_W'({wt_q, 1'b0});
        alu_op = ALU_SUB;
      end
      ST_PEAK: begin
        alu_a  = ALU_W'(peak_q);
        alu_b  = ALU_W'(quot_q);
        alu_op = ALU_SUB;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    ts_d        = ts_q;
    divr_d      = divr_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    wb_d        = wb_q;
    wt_d        = wt_q;
    peak_d      = peak_q;
    fin_d       = fin_q;
    ovf_d       = ovf_q;
    ovf_pend_d  = ovf_pend_q;
    eval_d      = eval_q;
    size_d      = size_q;
    tick_d      = tick_q;
    acc_d       = acc_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_if.ready;

    if (cfg_fire) begin
      case (cfg_if.data.index)
        REG_TIMESCALE: ts_d   = cfg_if.data.value;
        REG_DIVISOR:   divr_d = cfg_if.data.value[DIVR_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          fin_d      = (in_if.data.opcode == OP_FINALIZE);
          size_d     = size_in;
          tick_d     = tick_in;
          ovf_d      = (in_if.data.opcode == OP_FRAME) && fifo_full;
          ovf_pend_d = (in_if.data.opcode == OP_FRAME) && fifo_full;
        end
      end
      ST_EV_DIFF: acc_d = alu_sum;
      ST_DROP: begin
        wb_d       = WB_W'(alu_sum);
        wt_d       = WT_W'(acc_q);
        head_d     = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
        count_d    = count_q - CNT_W'(1);
        ovf_pend_d = 1'b0;
      end
      ST_PUSH_B: begin
        wb_d    = WB_W'(alu_sum);
        tail_d  = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
        count_d = count_q + CNT_W'(1);
      end
      ST_PUSH_T: wt_d = WT_W'(alu_sum);
      ST_CHECK: begin
        eval_d = (wt_q != '0) && (fin_q || alu_ge);
        acc_d  = '0;
        quot_d = {ts_q, {(RATE_W - TS_W){1'b0}}};
        cnt_d  = STEP_W'(TS_W - 1);
      end
      ST_MUL: begin
        acc_d  = alu_sum;
        quot_d = quot_q << 1;
        cnt_d  = cnt_q - STEP_W'(1);
      end
      ST_ADD_D: acc_d = alu_sum;
      ST_SAT: begin
        if (alu_ge) begin
          quot_d = '1;
        end else begin
          rem_d  = REM_W'(acc_q >> RATE_W);
          quot_d = acc_q[RATE_W-1:0];
          cnt_d  = STEP_W'(RATE_W - 1);
        end
      end
      ST_DIV: begin
        rem_d  = alu_ge ? REM_W'(alu_sum) : REM_W'(div_trial);
        quot_d = {quot_q[RATE_W-2:0], alu_ge};
        cnt_d  = cnt_q - STEP_W'(1);
      end
      ST_PEAK: begin
        if (!alu_ge) begin
          peak_d = quot_q;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.peak_bitrate   = peak_q;
          out_d.window_bitrate = eval_q ? quot_q : '0;
          out_d.window_evaluated = eval_q;
          out_d.fifo_overflow  = ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ts_q        <= TS_RESET;
      divr_q      <= DIVR_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      wb_q        <= '0;
      wt_q        <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ts_q        <= ts_d;
      divr_q      <= divr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      wb_q        <= wb_d;
      wt_q        <= wt_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    fin_q      <= fin_d;
    ovf_q      <= ovf_d;
    ovf_pend_q <= ovf_pend_d;
    eval_q     <= eval_d;
    size_q     <= size_d;
    tick_q     <= tick_d;
    acc_q      <= acc_d;
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    out_q      <= out_d;
  end

  // entry FIFO
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[tail_q] <= {size_q, tick_q};
    end
    rd_data_q <= entry_mem_q[head_q];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SWPB_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_FULL,
                    "FIFO count above depth")
  `SWPB_ASSERT_IMPL(a_empty_sums, (state_q == ST_IDLE) && (count_q == '0),
                    (wb_q == '0) && (wt_q == '0), "window sums nonzero with empty FIFO")
  `SWPB_ASSERT_NEXT(a_one_in_flight, in_if.valid && in_if.ready, !in_if.ready,
                    "input taken while an item is in flight")
  `SWPB_ASSERT_IMPL(a_rate_zero, out_valid_q && !out_q.window_evaluated,
                    out_q.window_bitrate == '0, "bitrate reported without evaluation")

endmodule

`default_nettype wire

// ----- tb/sliding_window_peak_bitrate_tb.sv -----
// Self-checking testbench for the sliding window peak bitrate tracker.
`default_nettype none

module sliding_window_peak_bitrate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swpb_pkg::*;

  localparam int FIFO_DEPTH    = 128;
  localparam int SIZE_BITS     = 16;
  localparam int IDLE_PCT      = 11;    // chance in a hundred that a side idles
  localparam int STALL_LIMIT   = 5000;  // cycles without any transaction
  localparam int TAIL_CYCLES   = 40;
  localparam int RESET_CYCLES  = 12;

  // Traffic shapes for the random phases.
  //   STEADY: regular AAC-like frames, one eviction per frame in steady state
  //   DENSE : tiny durations so the FIFO fills up and overflows
  //   WILD  : every field fully random
  //   BLEND : picks one of the above per item
  typedef enum int {
    MIX_STEADY,
    MIX_DENSE,
    MIX_WILD,
    MIX_BLEND
  } traffic_e;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  swpb_stream_if #(.T(in_item_t))  in_ch ();
  swpb_stream_if #(.T(out_item_t)) out_ch ();
  swpb_stream_if #(.T(cfg_item_t)) cfg_ch ();

  sliding_window_peak_bitrate #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .SIZE_BITS (SIZE_BITS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Window tracker: a software copy of the FIFO, its running sums, the peak
  // and the two registers. Advanced once per accepted input transaction.
  // --------------------------------------------------------------------------
  logic [BYTES_W-1:0] win_size  [FIFO_DEPTH];
  logic [TICK_W-1:0]  win_dur   [FIFO_DEPTH];
  int unsigned        win_head;
  int unsigned        win_count;
  longint unsigned    sum_bytes;
  longint unsigned    sum_ticks;
  logic [RATE_W-1:0]  peak_seen;
  logic [TS_W-1:0]    ts_reg;
  logic [DIVR_W-1:0]  div_reg;

  in_item_t  frames_to_send[$];     // items waiting for the driver
  out_item_t peak_reports_due[$];   // predicted results, oldest first
  int        mismatches;
  bit        steady;                // set for a phase with no idling at all

  function automatic void retire_oldest();
    sum_bytes -= win_size[win_head];
    sum_ticks -= win_dur[win_head];
    win_head   = (win_head + 1) % FIFO_DEPTH;
    win_count--;
  endfunction

  function automatic out_item_t track_window(in_item_t it);
    out_item_t       r;
    int unsigned     dv;
    int unsigned     slot;
    longint unsigned num;
    longint unsigned quo;
    logic [RATE_W-1:0] rate;
    r = '0;
    if (it.opcode == OP_FRAME) begin
      // divisor zero behaves as one; three really divides by three
      dv = (div_reg == '0) ? 1 : int'(div_reg);
      if (win_count >= FIFO_DEPTH) begin
        retire_oldest();
        r.fifo_overflow = 1'b1;
      end
      slot           = (win_head + win_count) % FIFO_DEPTH;
      win_size[slot] = it.frame_bytes;
      win_dur[slot]  = TICK_W'(int'(it.frame_samples) / dv);
      win_count++;
      sum_bytes += it.frame_bytes;
      sum_ticks += win_dur[slot];
    end
    // slide: drop the oldest while the rest still spans the timescale
    while (win_count != 0 && (sum_ticks - win_dur[win_head]) >= ts_reg)
      retire_oldest();
    // zero-length window never evaluates; finalize accepts a short one
    if (sum_ticks != 0 && (it.opcode == OP_FINALIZE || sum_ticks >= ts_reg)) begin
      num  = sum_bytes * 8 * ts_reg;
      quo  = (2 * num + sum_ticks) / (2 * sum_ticks);   // round half up
      rate = (quo > 64'h0000_0000_FFFF_FFFF) ? '1 : RATE_W'(quo);
      if (rate > peak_seen)
        peak_seen = rate;
      r.window_bitrate   = rate;
      r.window_evaluated = 1'b1;
    end
    r.peak_bitrate = peak_seen;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: takes the next item when the channel is free. The tracker
  // advances on the edge where the transaction completes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        peak_reports_due.insert(peak_reports_due.size(), track_window(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (frames_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= frames_to_send[0];
          frames_to_send.delete(0);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random back-pressure, field-by-field compare.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t due;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (peak_reports_due.size() == 0) begin
          $error("result transaction with nothing predicted");
          mismatches++;
        end else begin
          due = peak_reports_due[0];
          peak_reports_due.delete(0);
          if (out_ch.data.peak_bitrate !== due.peak_bitrate) begin
            $error("peak_bitrate: expected %0d, got %0d",
                   due.peak_bitrate, out_ch.data.peak_bitrate);
            mismatches++;
          end
          if (out_ch.data.window_bitrate !== due.window_bitrate) begin
            $error("window_bitrate: expected %0d, got %0d",
                   due.window_bitrate, out_ch.data.window_bitrate);
            mismatches++;
          end
          if (out_ch.data.window_evaluated !== due.window_evaluated) begin
            $error("window_evaluated: expected %0d, got %0d",
                   due.window_evaluated, out_ch.data.window_evaluated);
            mismatches++;
          end
          if (out_ch.data.fifo_overflow !== due.fifo_overflow) begin
            $error("fifo_overflow: expected %0d, got %0d",
                   due.fifo_overflow, out_ch.data.fifo_overflow);
            mismatches++;
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transaction on any channel restarts the count. The slowest
  // item (full FIFO evicted in one go, then a full evaluation) stays well
  // inside STALL_LIMIT.
  // --------------------------------------------------------------------------
  int stall_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("sliding_window_peak_bitrate: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One register write; the tracker picks the value up with the transaction.
  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_TIMESCALE)
      ts_reg = val[TS_W-1:0];
    else
      div_reg = val[DIVR_W-1:0];
  endtask

  task automatic set_regs(logic [TS_W-1:0] ts, logic [DIVR_W-1:0] dv);
    write_reg(REG_TIMESCALE, ts);
    write_reg(REG_DIVISOR, CFG_DATA_W'(dv));
    @(negedge clk);
  endtask

  task automatic send(op_e op, logic [BYTES_W-1:0] b, logic [TICK_W-1:0] s);
    in_item_t it;
    it = '{opcode: op, frame_bytes: b, frame_samples: s};
    frames_to_send.insert(frames_to_send.size(), it);
  endtask

  // Every item causes exactly one result, so once the last one is back the
  // sequencer is idle and registers may be written.
  task automatic settle();
    @(negedge clk);
    while (frames_to_send.size() != 0 || peak_reports_due.size() != 0 || in_ch.valid)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic in_item_t make_item(traffic_e mix);
    in_item_t it;
    traffic_e m;
    m = mix;
    if (m == MIX_BLEND)
      m = traffic_e'($urandom_range(2));
    // finalize now and then; its ignored fields stay random
    it.opcode        = ($urandom_range(11) == 0) ? OP_FINALIZE : OP_FRAME;
    it.frame_bytes   = BYTES_W'($urandom);
    it.frame_samples = TICK_W'($urandom);
    case (m)
      MIX_STEADY: begin
        if ($urandom_range(15) != 0)
          it.frame_bytes = BYTES_W'($urandom_range(1500, 60));
        if ($urandom_range(15) != 0)
          it.frame_samples = $urandom_range(1) ? 16'd1024 : 16'd2048;
      end
      MIX_DENSE: it.frame_samples = TICK_W'($urandom_range(200));
      default: ;
    endcase
    return it;
  endfunction

  task automatic random_phase(logic [TS_W-1:0] ts, logic [DIVR_W-1:0] dv, int n,
                              traffic_e mix, bit calm);
    set_regs(ts, dv);
    steady = calm;
    repeat (n) frames_to_send.insert(frames_to_send.size(), make_item(mix));
    settle();
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    mismatches   = 0;
    steady       = 1'b0;
    win_head     = 0;
    win_count    = 0;
    sum_bytes    = 0;
    sum_ticks    = 0;
    peak_seen    = '0;
    ts_reg       = TS_RESET;
    div_reg      = DIVR_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults straight out of reset (44100 ticks, divisor 1).
    send(OP_FINALIZE, 16'hFFFF, 16'hFFFF);   // empty window: no evaluation
    send(OP_FRAME, 16'd0, 16'd0);            // zero-length entry
    send(OP_FINALIZE, 16'd0, 16'd0);         // still zero ticks
    send(OP_FRAME, 16'hFFFF, 16'd1);
    send(OP_FINALIZE, 16'd0, 16'd0);         // short window, rate saturates
    send(OP_FRAME, 16'd0, 16'hFFFF);         // one frame spans the window
    send(OP_FRAME, 16'd1024, 16'd1024);
    send(OP_FINALIZE, 16'h5A5A, 16'hA5A5);
    settle();

    // Timescale zero drains the whole window; divisor three.
    set_regs('0, 2'd3);
    send(OP_FRAME, 16'd777, 16'd300);
    send(OP_FINALIZE, 16'd0, 16'd0);
    send(OP_FRAME, 16'hFFFF, 16'hFFFF);
    settle();

    // Largest timescale, divisor zero treated as one.
    set_regs('1, 2'd0);
    send(OP_FRAME, 16'hFFFF, 16'd1);
    send(OP_FINALIZE, 16'd0, 16'd0);
    send(OP_FRAME, 16'hFFFF, 16'hFFFF);
    send(OP_FRAME, 16'd0, 16'hFFFF);
    send(OP_FRAME, 16'd1, 16'hFFFF);
    send(OP_FINALIZE, 16'd0, 16'd0);
    settle();

    // Smallest legal timescale, SBR divisor: odd sample count rounds down.
    set_regs(18'd1, 2'd2);
    send(OP_FRAME, 16'd100, 16'd1);
    send(OP_FRAME, 16'd200, 16'd3);
    send(OP_FINALIZE, 16'd0, 16'd0);
    settle();

    // Random phases; the dense one runs without any idling and keeps the
    // FIFO full, the wild one right after evicts almost the whole FIFO.
    random_phase(18'd44100,  2'd1, 200, MIX_STEADY, 1'b0);
    random_phase(18'd48000,  2'd2, 150, MIX_STEADY, 1'b0);
    random_phase(18'd192000, 2'd2, 200, MIX_DENSE,  1'b1);
    random_phase(18'd1,      2'd1, 100, MIX_WILD,   1'b0);
    random_phase('1,         2'd3, 150, MIX_BLEND,  1'b0);
    random_phase('0,         2'd0,  50, MIX_WILD,   1'b0);
    random_phase(TS_W'($urandom_range(192000, 1)), DIVR_W'($urandom_range(3)), 200,
                 MIX_BLEND, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && peak_reports_due.size() == 0)
      $display("sliding_window_peak_bitrate: match");
    else
      $display("sliding_window_peak_bitrate: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/swpb_pkg.sv
design/swpb_stream_if.sv
design/swpb_alu.sv
design/sliding_window_peak_bitrate.sv
tb/sliding_window_peak_bitrate_tb.sv
